/* rtl/core/sssg_pkg.sv */
// ----------------------------------------------------------------------------
// sssg_pkg
// Shared types and constants for the square and saw sound generator.
// ----------------------------------------------------------------------------
package sssg_pkg;

    localparam int MAX_TICK_CYCLES_DEF = 8;
    localparam int QUEUE_DEPTH         = 4;
    localparam int CYCLES_W            = 4;
    localparam int PERIOD_W            = 12;
    localparam int COUNT_W             = PERIOD_W + 1;
    localparam int SAMPLE_W            = 15;
    localparam int MIX_W               = 7;

    localparam logic [3:0]  PAGE_PULSE0 = 4'h9;
    localparam logic [3:0]  PAGE_PULSE1 = 4'hA;
    localparam logic [3:0]  PAGE_SAW    = 4'hB;
    localparam logic [11:0] SEL_CTRL    = 12'd0;
    localparam logic [11:0] SEL_LO      = 12'd1;
    localparam logic [11:0] SEL_HI      = 12'd2;

    localparam logic [3:0] SAW_STEPS = 4'd14;
    localparam logic       OP_WRITE  = 1'b0;

    typedef enum logic [3:0] {
        CMD_P0_CTRL,
        CMD_P0_LO,
        CMD_P0_HI,
        CMD_P1_CTRL,
        CMD_P1_LO,
        CMD_P1_HI,
        CMD_SAW_CTRL,
        CMD_SAW_LO,
        CMD_SAW_HI,
        CMD_TICK
    } cmd_op_t;

    typedef struct packed {
        cmd_op_t               op;
        logic [7:0]            data;
        logic [CYCLES_W-1:0]   cycles;
    } cmd_t;

endpackage

/* rtl/core/square_saw_sound_generator_unit.sv */
// ----------------------------------------------------------------------------
// square_saw_sound_generator_unit
// Two pulse channels and one sawtooth channel with a mixed sample output.
// ----------------------------------------------------------------------------
// A register write transaction is decoded on entry and applied by the channel
// engine at the clock edge that takes it from the command queue, in the cycle
// after acceptance when the engine is idle; writes to unmatched addresses are
// dropped at the input. A tick transaction occupies the engine while it is
// fetched, while the channel down counters are stepped once per elapsed clock,
// and while the sample is mixed; the mix waits until any held sample is taken.
// The input side keeps accepting into the queue while the engine works or a
// sample waits, until the queue is full.
module square_saw_sound_generator_unit #(
    parameter int MAX_TICK_CYCLES = sssg_pkg::MAX_TICK_CYCLES_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic                          s_operation,
    input  logic [15:0]                   s_address,
    input  logic [7:0]                    s_write_data,
    input  logic [sssg_pkg::CYCLES_W-1:0] s_cycles,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic signed [sssg_pkg::SAMPLE_W-1:0] m_sample
);

    logic           q_full;
    logic           q_push;
    sssg_pkg::cmd_t q_push_cmd;
    logic           q_pop;
    logic           q_valid;
    sssg_pkg::cmd_t q_cmd;

    sssg_front #(
        .MAX_TICK_CYCLES(MAX_TICK_CYCLES)
    ) u_front (
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_operation (s_operation),
        .s_address   (s_address),
        .s_write_data(s_write_data),
        .s_cycles    (s_cycles),
        .q_full      (q_full),
        .q_push      (q_push),
        .q_cmd       (q_push_cmd)
    );

    sssg_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (q_push),
        .push_cmd (q_push_cmd),
        .full     (q_full),
        .pop      (q_pop),
        .cmd_valid(q_valid),
        .cmd      (q_cmd)
    );

    sssg_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cmd_valid(q_valid),
        .cmd      (q_cmd),
        .cmd_pop  (q_pop),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_sample (m_sample)
    );

endmodule

/* rtl/core/sssg_front.sv */
// ----------------------------------------------------------------------------
// sssg_front
// Accepts input transactions, decodes the register address and queues
// commands; writes to unmatched addresses are dropped here.
// ----------------------------------------------------------------------------
module sssg_front #(
    parameter int MAX_TICK_CYCLES = sssg_pkg::MAX_TICK_CYCLES_DEF
) (
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic                          s_operation,
    input  logic [15:0]                   s_address,
    input  logic [7:0]                    s_write_data,
    input  logic [sssg_pkg::CYCLES_W-1:0] s_cycles,
    input  logic                          q_full,
    output logic                          q_push,
    output sssg_pkg::cmd_t                q_cmd
);

    logic [3:0]  page;
    logic [11:0] sel;
    logic        matched;

    assign page    = s_address[15:12];
    assign sel     = s_address[11:0];
    assign s_ready = !q_full;

    always_comb begin
        matched       = 1'b1;
        q_cmd.data    = s_write_data;
        q_cmd.cycles  = s_cycles;
        q_cmd.op      = sssg_pkg::CMD_TICK;
        if (s_operation != sssg_pkg::OP_WRITE) begin
            if (32'(s_cycles) > 32'(MAX_TICK_CYCLES)) begin
                q_cmd.cycles = sssg_pkg::CYCLES_W'(MAX_TICK_CYCLES);
            end
        end else if (sel > sssg_pkg::SEL_HI) begin
            matched = 1'b0;
        end else begin
            unique case (page)
                sssg_pkg::PAGE_PULSE0: begin
                    q_cmd.op = (sel == sssg_pkg::SEL_CTRL) ? sssg_pkg::CMD_P0_CTRL :
                               (sel == sssg_pkg::SEL_LO)   ? sssg_pkg::CMD_P0_LO :
                                                             sssg_pkg::CMD_P0_HI;
                end
                sssg_pkg::PAGE_PULSE1: begin
                    q_cmd.op = (sel == sssg_pkg::SEL_CTRL) ? sssg_pkg::CMD_P1_CTRL :
                               (sel == sssg_pkg::SEL_LO)   ? sssg_pkg::CMD_P1_LO :
                                                             sssg_pkg::CMD_P1_HI;
                end
                sssg_pkg::PAGE_SAW: begin
                    q_cmd.op = (sel == sssg_pkg::SEL_CTRL) ? sssg_pkg::CMD_SAW_CTRL :
                               (sel == sssg_pkg::SEL_LO)   ? sssg_pkg::CMD_SAW_LO :
                                                             sssg_pkg::CMD_SAW_HI;
                end
                default: begin
                    matched = 1'b0;
                end
            endcase
        end
    end

    assign q_push = s_valid && s_ready && matched;

endmodule

/* rtl/core/sssg_queue.sv */
// ----------------------------------------------------------------------------
// sssg_queue
// Short command queue between the decoder and the channel engine.
// ----------------------------------------------------------------------------
module sssg_queue (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           push,
    input  sssg_pkg::cmd_t push_cmd,
    output logic           full,
    input  logic           pop,
    output logic           cmd_valid,
    output sssg_pkg::cmd_t cmd
);

    localparam int PTR_W = (sssg_pkg::QUEUE_DEPTH > 1) ? $clog2(sssg_pkg::QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(sssg_pkg::QUEUE_DEPTH + 1);

    sssg_pkg::cmd_t mem [sssg_pkg::QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_pop;

    assign full      = (count_reg == CNT_W'(sssg_pkg::QUEUE_DEPTH));
    assign cmd_valid = (count_reg != '0);
    assign cmd       = mem[rd_ptr_reg];
    assign do_pop    = pop && cmd_valid;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(sssg_pkg::QUEUE_DEPTH - 1)) ? '0
                                                                             : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(sssg_pkg::QUEUE_DEPTH - 1)) ? '0
                                                                             : rd_ptr_reg + 1'b1;
        end
        if (push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (!push && do_pop) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_ptr_reg] <= push_cmd;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

/* rtl/core/sssg_back.sv */
// ----------------------------------------------------------------------------
// sssg_back
// Channel engine: applies register writes, steps the two pulse channels and
// the saw channel one clock at a time, then mixes and holds the sample.
// ----------------------------------------------------------------------------
module sssg_back (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cmd_valid,
    input  sssg_pkg::cmd_t                cmd,
    output logic                          cmd_pop,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic signed [sssg_pkg::SAMPLE_W-1:0] m_sample
);

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_RUN  = 2'b10
    } back_state_t;

    localparam int PW = sssg_pkg::PERIOD_W;
    localparam int CW = sssg_pkg::COUNT_W;
    localparam int MW = sssg_pkg::MIX_W;

    back_state_t state_reg, state_next;
    logic [sssg_pkg::CYCLES_W-1:0] remain_reg, remain_next;

    logic [7:0]    p_ctrl_reg   [2];
    logic [7:0]    p_ctrl_next  [2];
    logic [PW-1:0] p_period_reg [2];
    logic [PW-1:0] p_period_next[2];
    logic [1:0]    p_en_reg, p_en_next;
    logic [3:0]    p_phase_reg  [2];
    logic [3:0]    p_phase_next [2];
    logic [CW-1:0] p_cd_reg     [2];
    logic [CW-1:0] p_cd_next    [2];

    logic [5:0]    s_rate_reg, s_rate_next;
    logic [PW-1:0] s_period_reg, s_period_next;
    logic          s_en_reg, s_en_next;
    logic [7:0]    s_level_reg, s_level_next;
    logic [3:0]    s_step_reg, s_step_next;
    logic [CW-1:0] s_cd_reg, s_cd_next;
    logic [3:0]    s_step_inc;

    logic                              out_valid_reg, out_valid_next;
    logic signed [sssg_pkg::SAMPLE_W-1:0] out_sample_reg, out_sample_next;

    logic signed [MW-1:0] mix;
    logic signed [MW-1:0] p_term [2];
    logic signed [MW-1:0] s_term;
    logic                 finish;

    assign m_valid  = out_valid_reg;
    assign m_sample = out_sample_reg;
    assign finish   = (state_reg == ST_RUN) && (remain_reg == '0)
                      && (!out_valid_reg || m_ready);
    assign cmd_pop  = (state_reg == ST_IDLE) && cmd_valid;

    // mixer
    always_comb begin
        for (int ch = 0; ch < 2; ch++) begin
            if (!p_en_reg[ch]) begin
                p_term[ch] = '0;
            end else if (p_ctrl_reg[ch][7] || (p_phase_reg[ch] <= {1'b0, p_ctrl_reg[ch][6:4]}))
            begin
                p_term[ch] = MW'({3'b000, p_ctrl_reg[ch][3:0]});
            end else begin
                p_term[ch] = -MW'({3'b000, p_ctrl_reg[ch][3:0]});
            end
        end
        if (s_en_reg) begin
            s_term = MW'({1'b0, s_level_reg[7:3], 1'b0}) - MW'(32);
        end else begin
            s_term = '0;
        end
        mix = p_term[0] + p_term[1] + s_term;
    end

    assign s_step_inc = (s_step_reg + 4'd1 >= sssg_pkg::SAW_STEPS) ? 4'd0 : s_step_reg + 4'd1;

    always_comb begin
        state_next      = state_reg;
        remain_next     = remain_reg;
        p_ctrl_next     = p_ctrl_reg;
        p_period_next   = p_period_reg;
        p_en_next       = p_en_reg;
        p_phase_next    = p_phase_reg;
        p_cd_next       = p_cd_reg;
        s_rate_next     = s_rate_reg;
        s_period_next   = s_period_reg;
        s_en_next       = s_en_reg;
        s_level_next    = s_level_reg;
        s_step_next     = s_step_reg;
        s_cd_next       = s_cd_reg;
        out_valid_next  = out_valid_reg && !m_ready;
        out_sample_next = out_sample_reg;

        unique case (state_reg)
            ST_IDLE: begin
                if (cmd_valid) begin
                    unique case (cmd.op)
                        sssg_pkg::CMD_P0_CTRL:  p_ctrl_next[0] = cmd.data;
                        sssg_pkg::CMD_P0_LO:    p_period_next[0][7:0] = cmd.data;
                        sssg_pkg::CMD_P0_HI: begin
                            p_period_next[0][PW-1:8] = cmd.data[3:0];
                            p_en_next[0]             = cmd.data[7];
                        end
                        sssg_pkg::CMD_P1_CTRL:  p_ctrl_next[1] = cmd.data;
                        sssg_pkg::CMD_P1_LO:    p_period_next[1][7:0] = cmd.data;
                        sssg_pkg::CMD_P1_HI: begin
                            p_period_next[1][PW-1:8] = cmd.data[3:0];
                            p_en_next[1]             = cmd.data[7];
                        end
                        sssg_pkg::CMD_SAW_CTRL: s_rate_next = cmd.data[5:0];
                        sssg_pkg::CMD_SAW_LO:   s_period_next[7:0] = cmd.data;
                        sssg_pkg::CMD_SAW_HI: begin
                            s_period_next[PW-1:8] = cmd.data[3:0];
                            s_en_next             = cmd.data[7];
                        end
                        sssg_pkg::CMD_TICK: begin
                            remain_next = cmd.cycles;
                            state_next  = ST_RUN;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_RUN: begin
                if (remain_reg != '0) begin
                    remain_next = remain_reg - 1'b1;
                    for (int ch = 0; ch < 2; ch++) begin
                        if (p_en_reg[ch]) begin
                            if (p_cd_reg[ch] == CW'(1)) begin
                                p_cd_next[ch]    = {1'b0, p_period_reg[ch]} + CW'(1);
                                p_phase_next[ch] = p_phase_reg[ch] + 4'd1;
                            end else begin
                                p_cd_next[ch] = p_cd_reg[ch] - CW'(1);
                            end
                        end
                    end
                    if (s_en_reg) begin
                        if (s_cd_reg == CW'(1)) begin
                            s_cd_next   = {1'b0, s_period_reg} + CW'(1);
                            s_step_next = s_step_inc;
                            if (s_step_inc == 4'd0) begin
                                s_level_next = '0;
                            end else if (!s_step_inc[0]) begin
                                s_level_next = s_level_reg + {2'b00, s_rate_reg};
                            end
                        end else begin
                            s_cd_next = s_cd_reg - CW'(1);
                        end
                    end
                end else if (finish) begin
                    out_valid_next  = 1'b1;
                    out_sample_next = {mix, 8'h00};
                    state_next      = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            remain_reg    <= '0;
            out_valid_reg <= 1'b0;
            p_en_reg      <= '0;
            s_rate_reg    <= '0;
            s_period_reg  <= '0;
            s_en_reg      <= 1'b0;
            s_level_reg   <= '0;
            s_step_reg    <= '0;
            s_cd_reg      <= CW'(1);
            for (int ch = 0; ch < 2; ch++) begin
                p_ctrl_reg[ch]   <= '0;
                p_period_reg[ch] <= '0;
                p_phase_reg[ch]  <= '0;
                p_cd_reg[ch]     <= CW'(1);
            end
        end else begin
            state_reg     <= state_next;
            remain_reg    <= remain_next;
            out_valid_reg <= out_valid_next;
            p_ctrl_reg    <= p_ctrl_next;
            p_period_reg  <= p_period_next;
            p_en_reg      <= p_en_next;
            p_phase_reg   <= p_phase_next;
            p_cd_reg      <= p_cd_next;
            s_rate_reg    <= s_rate_next;
            s_period_reg  <= s_period_next;
            s_en_reg      <= s_en_next;
            s_level_reg   <= s_level_next;
            s_step_reg    <= s_step_next;
            s_cd_reg      <= s_cd_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_sample_reg <= out_sample_next;
    end

    a_result_from_run: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(state_reg == ST_RUN))
        else $error("sample raised outside a tick");

    a_pop_when_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd_pop |-> (state_reg == ST_IDLE))
        else $error("command taken while busy");

    a_step_count: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_RUN && remain_reg != '0)
            |=> (remain_reg == $past(remain_reg) - 1'b1) && (state_reg == ST_RUN))
        else $error("cycle counter skipped");

    a_counter_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_cd_reg != '0) && (p_cd_reg[0] != '0) && (p_cd_reg[1] != '0))
        else $error("channel counter reached zero");

endmodule

/* tb/sv/tb_square_saw_sound_generator_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_square_saw_sound_generator_unit
// Drives register writes and tick transactions into the sound generator and
// checks every mixed sample against a cycle-stepped model of the two pulse
// channels and the saw channel. Directed edge cases come first, then random
// traffic with idle bursts on both sides, a long output stall, and a final
// stream at full rate.
// ----------------------------------------------------------------------------
module tb_square_saw_sound_generator_unit;

    localparam logic        OP_WRITE            = sssg_pkg::OP_WRITE;
    localparam int          MAX_TICK_CYCLES_DEF = sssg_pkg::MAX_TICK_CYCLES_DEF;
    localparam int          QUEUE_DEPTH         = sssg_pkg::QUEUE_DEPTH;
    localparam int          CYCLES_W            = sssg_pkg::CYCLES_W;
    localparam int          SAMPLE_W            = sssg_pkg::SAMPLE_W;
    localparam logic [3:0]  PAGE_PULSE0         = sssg_pkg::PAGE_PULSE0;
    localparam logic [3:0]  PAGE_PULSE1         = sssg_pkg::PAGE_PULSE1;
    localparam logic [3:0]  PAGE_SAW            = sssg_pkg::PAGE_SAW;
    localparam logic [11:0] SEL_CTRL            = sssg_pkg::SEL_CTRL;
    localparam logic [11:0] SEL_LO              = sssg_pkg::SEL_LO;
    localparam logic [11:0] SEL_HI              = sssg_pkg::SEL_HI;
    localparam logic [3:0]  SAW_STEPS           = sssg_pkg::SAW_STEPS;

    localparam logic OP_TICK      = ~OP_WRITE;
    localparam int   TICK_LIMIT   = MAX_TICK_CYCLES_DEF;
    localparam int   HOLD_CYCLES  = 300;
    localparam int   DRAIN_CYCLES = (TICK_LIMIT + 2) * (QUEUE_DEPTH + 2);
    localparam int   STALL_LIMIT  = 2000;

    logic                       aclk         = 1'b0;
    logic                       aresetn      = 1'b0;
    logic                       s_valid      = 1'b0;
    logic                       s_ready;
    logic                       s_operation  = OP_WRITE;
    logic [15:0]                s_address    = '0;
    logic [7:0]                 s_write_data = '0;
    logic [CYCLES_W-1:0]        s_cycles     = '0;
    logic                       m_valid;
    logic                       m_ready      = 1'b0;
    logic signed [SAMPLE_W-1:0] m_sample;

    // model of the channel state
    logic [7:0]  pulse_ctrl   [2] = '{8'd0, 8'd0};
    logic [11:0] pulse_period [2] = '{12'd0, 12'd0};
    logic        pulse_on     [2] = '{1'b0, 1'b0};
    logic [3:0]  pulse_phase  [2] = '{4'd0, 4'd0};
    logic [13:0] pulse_count  [2] = '{14'd1, 14'd1};
    logic [5:0]  saw_rate     = '0;
    logic [11:0] saw_period   = '0;
    logic        saw_on       = 1'b0;
    logic [7:0]  saw_level    = '0;
    logic [3:0]  saw_index    = '0;
    logic [13:0] saw_count    = 14'd1;

    logic signed [SAMPLE_W-1:0] pending_samples [$];
    logic signed [SAMPLE_W-1:0] want_sample;

    bit src_idle_on = 1'b1;
    bit snk_idle_on = 1'b1;
    bit hold_req    = 1'b0;
    int write_count = 0;
    int tick_count  = 0;
    int match_count = 0;
    int fail_count  = 0;
    int idle_cycles = 0;

    square_saw_sound_generator_unit u_top (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_operation  (s_operation),
        .s_address    (s_address),
        .s_write_data (s_write_data),
        .s_cycles     (s_cycles),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_sample     (m_sample)
    );

    always #6 aclk = ~aclk;

    function automatic void apply_register_write(input logic [15:0] addr,
                                                 input logic [7:0] data);
        logic [3:0]  page;
        logic [11:0] sel;
        int          ch;
        page = addr[15:12];
        sel  = addr[11:0];
        if (page == PAGE_PULSE0 || page == PAGE_PULSE1) begin
            ch = (page == PAGE_PULSE0) ? 0 : 1;
            case (sel)
                SEL_CTRL: pulse_ctrl[ch] = data;
                SEL_LO:   pulse_period[ch][7:0] = data;
                SEL_HI: begin
                    pulse_period[ch][11:8] = data[3:0];
                    pulse_on[ch] = data[7];
                end
                default: ;
            endcase
        end else if (page == PAGE_SAW) begin
            case (sel)
                SEL_CTRL: saw_rate = data[5:0];
                SEL_LO:   saw_period[7:0] = data;
                SEL_HI: begin
                    saw_period[11:8] = data[3:0];
                    saw_on = data[7];
                end
                default: ;
            endcase
        end
    endfunction

    function automatic logic signed [SAMPLE_W-1:0] advance_and_mix(input logic [3:0] cyc);
        int n;
        int mix;
        n   = (int'(cyc) > TICK_LIMIT) ? TICK_LIMIT : int'(cyc);
        mix = 0;
        for (int ch = 0; ch < 2; ch++) begin
            if (pulse_on[ch]) begin
                repeat (n) begin
                    pulse_count[ch] = pulse_count[ch] - 14'd1;
                    if (pulse_count[ch] == '0) begin
                        pulse_phase[ch] = pulse_phase[ch] + 4'd1;
                        pulse_count[ch] = {2'b00, pulse_period[ch]} + 14'd1;
                    end
                end
                if (pulse_ctrl[ch][7] || pulse_phase[ch] <= {1'b0, pulse_ctrl[ch][6:4]})
                    mix += int'(pulse_ctrl[ch][3:0]);
                else
                    mix -= int'(pulse_ctrl[ch][3:0]);
            end
        end
        if (saw_on) begin
            repeat (n) begin
                saw_count = saw_count - 14'd1;
                if (saw_count == '0) begin
                    saw_index = (saw_index + 4'd1 >= SAW_STEPS) ? 4'd0 : saw_index + 4'd1;
                    if (saw_index == 4'd0)
                        saw_level = '0;
                    else if (!saw_index[0])
                        saw_level = saw_level + {2'b00, saw_rate};
                    saw_count = {2'b00, saw_period} + 14'd1;
                end
            end
            mix += (int'(saw_level[7:3]) - 16) * 2;
        end
        return SAMPLE_W'(mix * 256);
    endfunction

    task automatic send_txn(input logic op, input logic [15:0] addr,
                            input logic [7:0] data, input logic [3:0] cyc);
        if (src_idle_on && $urandom_range(0, 4) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge aclk);
        end
        s_valid      <= 1'b1;
        s_operation  <= op;
        s_address    <= addr;
        s_write_data <= data;
        s_cycles     <= cyc;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        if (op == OP_WRITE) begin
            apply_register_write(addr, data);
            write_count++;
        end else begin
            pending_samples.push_back(advance_and_mix(cyc));
            tick_count++;
        end
    endtask

    task automatic drain_samples();
        s_valid <= 1'b0;
        while (pending_samples.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic send_random_txn();
        logic [3:0]  page;
        logic [11:0] sel;
        logic [7:0]  data;
        logic [3:0]  cyc;
        int          pick;
        pick = $urandom_range(0, 99);
        data = 8'($urandom);
        cyc  = 4'($urandom_range(1, TICK_LIMIT));
        if ($urandom_range(0, 9) == 0)
            cyc = 4'($urandom);
        case ($urandom_range(0, 2))
            0:       page = PAGE_PULSE0;
            1:       page = PAGE_PULSE1;
            default: page = PAGE_SAW;
        endcase
        case ($urandom_range(0, 2))
            0:       sel = SEL_CTRL;
            1:       sel = SEL_LO;
            default: sel = SEL_HI;
        endcase
        // short periods keep the channels stepping within a tick
        if (sel == SEL_LO && $urandom_range(0, 1) == 0)
            data = 8'($urandom_range(0, 7));
        if (sel == SEL_HI) begin
            data[7] = ($urandom_range(0, 4) != 0);
            if ($urandom_range(0, 3) != 0)
                data[3:0] = '0;
        end
        if (pick < 45)
            send_txn(OP_TICK, 16'($urandom), 8'($urandom), cyc);
        else if (pick < 92)
            send_txn(OP_WRITE, {page, sel}, data, 4'($urandom));
        else
            send_txn(OP_WRITE, 16'($urandom), data, 4'($urandom));
    endtask

    task automatic test_silent_mix();
        send_txn(OP_TICK, 16'h0000, 8'h00, 4'd1);
        send_txn(OP_TICK, 16'hFFFF, 8'hFF, 4'd8);
    endtask

    task automatic test_pulse_channels();
        send_txn(OP_WRITE, {PAGE_PULSE0, SEL_CTRL}, 8'hFF, 4'd0);
        send_txn(OP_WRITE, {PAGE_PULSE0, SEL_LO},   8'h00, 4'd0);
        send_txn(OP_WRITE, {PAGE_PULSE0, SEL_HI},   8'h80, 4'd0);
        send_txn(OP_TICK,  16'h0000, 8'h00, 4'd8);
        send_txn(OP_WRITE, {PAGE_PULSE1, SEL_CTRL}, 8'h0F, 4'd0);
        send_txn(OP_WRITE, {PAGE_PULSE1, SEL_LO},   8'hFF, 4'd0);
        send_txn(OP_WRITE, {PAGE_PULSE1, SEL_HI},   8'h8F, 4'd0);
        send_txn(OP_TICK,  16'h0000, 8'h00, 4'd8);
    endtask

    task automatic test_saw_channel();
        // unused rate and high-byte bits are set to show they are dropped
        send_txn(OP_WRITE, {PAGE_SAW, SEL_CTRL}, 8'hFF, 4'd0);
        send_txn(OP_WRITE, {PAGE_SAW, SEL_LO},   8'h01, 4'd0);
        send_txn(OP_WRITE, {PAGE_SAW, SEL_HI},   8'hF0, 4'd0);
        send_txn(OP_TICK,  16'h0000, 8'h00, 4'd8);
        send_txn(OP_TICK,  16'h0000, 8'h00, 4'd15);
        send_txn(OP_TICK,  16'h0000, 8'h00, 4'd0);
    endtask

    task automatic test_unmatched_address();
        send_txn(OP_WRITE, {PAGE_PULSE0, SEL_HI + 12'd1}, 8'h00, 4'd0);
        send_txn(OP_WRITE, {PAGE_SAW, SEL_HI + 12'd1},    8'h00, 4'd0);
        send_txn(OP_WRITE, 16'hA100, 8'h00, 4'd0);
        send_txn(OP_WRITE, 16'hC000, 8'h00, 4'd0);
        send_txn(OP_WRITE, 16'h0000, 8'h00, 4'd0);
        send_txn(OP_WRITE, 16'hFFFF, 8'h00, 4'd0);
        send_txn(OP_TICK,  16'h0000, 8'h00, 4'd8);
    endtask

    task automatic test_period_and_disable();
        // counter keeps running down from the old long period
        send_txn(OP_WRITE, {PAGE_PULSE1, SEL_LO}, 8'h00, 4'd0);
        send_txn(OP_WRITE, {PAGE_PULSE1, SEL_HI}, 8'h80, 4'd0);
        send_txn(OP_TICK,  16'h0000, 8'h00, 4'd8);
        send_txn(OP_WRITE, {PAGE_PULSE0, SEL_HI}, 8'h00, 4'd0);
        send_txn(OP_TICK,  16'h0000, 8'h00, 4'd4);
    endtask

    task automatic test_random_traffic(input int count);
        repeat (count) send_random_txn();
    endtask

    task automatic test_output_backpressure();
        hold_req = 1'b1;
        repeat (40) send_txn(OP_TICK, 16'($urandom), 8'($urandom),
                             4'($urandom_range(1, TICK_LIMIT)));
        drain_samples();
    endtask

    task automatic test_full_rate_stream(input int count);
        src_idle_on = 1'b0;
        snk_idle_on = 1'b0;
        repeat (count) send_random_txn();
    endtask

    // result side: random stalls plus one long hold-off on request
    initial begin
        forever begin
            @(posedge aclk);
            if (hold_req) begin
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
                hold_req = 1'b0;
                m_ready <= 1'b1;
            end else if (snk_idle_on && $urandom_range(0, 4) == 0) begin
                m_ready <= 1'b0;
                repeat ($urandom_range(1, 8)) @(posedge aclk);
                m_ready <= 1'b1;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (pending_samples.size() == 0) begin
                $error("sample with no transaction pending: %0d", m_sample);
                fail_count++;
            end else begin
                want_sample = pending_samples.pop_front();
                if (m_sample !== want_sample) begin
                    $error("sample mismatch: expected %0d, actual %0d", want_sample, m_sample);
                    fail_count++;
                end else begin
                    match_count++;
                end
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= STALL_LIMIT) begin
            $display("timeout: no transaction for %0d cycles", STALL_LIMIT);
            $display("FAILURE");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_silent_mix();
        test_pulse_channels();
        test_saw_channel();
        test_unmatched_address();
        test_period_and_disable();
        test_random_traffic(1100);
        test_output_backpressure();
        test_full_rate_stream(550);
        drain_samples();
        $display("run covered %0d register writes and %0d ticks, %0d samples matched",
                 write_count, tick_count, match_count);
        $display("edge cases, random idle bursts, a long output stall and a full-rate stream");
        if (fail_count == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
